### src/cbd_pkg.sv
// Package for the compressed block deframer.
// Holds link characters, result codes and the result record; no dependencies.
package cbd_pkg;

  localparam int TitleMaxDefault  = 80;
  localparam int OffsetMaxDefault = 6;

  localparam int ByteW   = 8;
  localparam int KindW   = 2;
  localparam int ErrW    = 3;
  localparam int HdrCntW = 8;
  localparam int BlkW    = 9;

  localparam logic [ByteW-1:0] ChrNul    = 8'h00;
  localparam logic [ByteW-1:0] ChrSoh    = 8'h01;
  localparam logic [ByteW-1:0] ChrStx    = 8'h02;
  localparam logic [ByteW-1:0] ChrEot    = 8'h04;
  localparam logic [ByteW-1:0] AsciiZero = 8'h30;

  localparam logic [KindW-1:0] KindData  = 2'd0;
  localparam logic [KindW-1:0] KindGood  = 2'd1;
  localparam logic [KindW-1:0] KindError = 2'd2;

  localparam logic [ErrW-1:0] ErrNone      = 3'd0;
  localparam logic [ErrW-1:0] ErrNoSoh     = 3'd1;
  localparam logic [ErrW-1:0] ErrNoNul     = 3'd2;
  localparam logic [ErrW-1:0] ErrHdrLen    = 3'd3;
  localparam logic [ErrW-1:0] ErrOffset    = 3'd4;
  localparam logic [ErrW-1:0] ErrBodyByte  = 3'd5;
  localparam logic [ErrW-1:0] ErrChecksum  = 3'd6;

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data;
    logic [KindW-1:0] kind;
    logic [ErrW-1:0]  err;
  } cbd_res_t;

endpackage

### src/compressed_block_deframer_unit.sv
// Top level of the compressed block deframer: input register, frame state
// machine and result register. Depends on cbd_pkg, cbd_fsm and cbd_out_reg.
//
//   channel  direction  handshake                payload
//   input    in         in_valid_i / in_stall_o  rx_byte_i
//   output   out        out_valid_o / out_stall_i data_o, kind_o, error_code_o
//
// One byte per cycle sustained while the output does not stall; a byte's result
// passes first through the input register and then through the result register.
// The frame state machine steps once per byte, limiting throughput to one byte.
// Reset clears the frame state to awaiting start of header, both registers empty.
// An output stall holds the result register, then the input register, then
// raises in_stall_o; bytes that give no result still need a free result slot.
module compressed_block_deframer_unit
  import cbd_pkg::*;
#(
  parameter int TitleMax  = TitleMaxDefault,
  parameter int OffsetMax = OffsetMaxDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] rx_byte_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ByteW-1:0] data_o,
  output logic [KindW-1:0] kind_o,
  output logic [ErrW-1:0]  error_code_o
);

  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             step;
  logic             in_take;
  cbd_res_t         res;

  assign step       = in_valid_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = in_valid_q && !step;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= rx_byte_i;
    end
  end

  cbd_fsm #(
    .TitleMax (TitleMax),
    .OffsetMax(OffsetMax)
  ) u_fsm (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(step),
    .byte_i(in_byte_q),
    .res_o (res)
  );

  cbd_out_reg u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (step),
    .res_i  (res),
    .stall_i(out_stall_i),
    .valid_o(out_valid_o),
    .data_o (data_o),
    .kind_o (kind_o),
    .err_o  (error_code_o)
  );

`ifndef SYNTHESIS
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !step |=> in_valid_q && $stable(in_byte_q))
    else $error("input register lost a stalled request");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !step |=> !out_valid_o)
    else $error("result delivered twice");

  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KindData |-> data_o == '0)
    else $error("non-payload result carries data");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((kind_o == KindError) == (error_code_o != ErrNone)))
    else $error("error code does not match result kind");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> kind_o == KindData || kind_o == KindGood || kind_o == KindError)
    else $error("result kind out of range");
`endif

endmodule

### src/cbd_fsm.sv
// Frame state machine of the compressed block deframer: state registers and
// the per-byte step logic. Depends on cbd_pkg.
module cbd_fsm
  import cbd_pkg::*;
#(
  parameter int TitleMax  = TitleMaxDefault,
  parameter int OffsetMax = OffsetMaxDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [ByteW-1:0] byte_i,
  output cbd_res_t         res_o
);

  localparam int FieldMax = (TitleMax > OffsetMax) ? TitleMax : OffsetMax;
  localparam int FcW      = $clog2(FieldMax + 1);

  localparam logic [2:0] PhIdle   = 3'd0;
  localparam logic [2:0] PhHlen   = 3'd1;
  localparam logic [2:0] PhTitle  = 3'd2;
  localparam logic [2:0] PhOffset = 3'd3;
  localparam logic [2:0] PhBody   = 3'd4;
  localparam logic [2:0] PhCount  = 3'd5;
  localparam logic [2:0] PhData   = 3'd6;
  localparam logic [2:0] PhCheck  = 3'd7;

  logic [2:0]         phase_q, phase_d;
  logic [ByteW-1:0]   hdr_len_q, hdr_len_d;
  logic [HdrCntW-1:0] hdr_cnt_q, hdr_cnt_d;
  logic [FcW-1:0]     field_cnt_q, field_cnt_d;
  logic               off_zero_q, off_zero_d;
  logic [BlkW-1:0]    blk_rem_q, blk_rem_d;
  logic [ByteW-1:0]   sum_q, sum_d;

  logic [HdrCntW-1:0] hdr_cnt_inc;
  logic [BlkW-1:0]    blk_rem_dec;
  logic [ByteW-1:0]   sum_add;

  assign hdr_cnt_inc = hdr_cnt_q + HdrCntW'(1);
  assign blk_rem_dec = blk_rem_q - BlkW'(1);
  assign sum_add     = sum_q + byte_i;

  function automatic cbd_res_t mk_res(logic [ByteW-1:0] d, logic [KindW-1:0] k,
                                      logic [ErrW-1:0] e);
    cbd_res_t r;
    r.valid = 1'b1;
    r.data  = d;
    r.kind  = k;
    r.err   = e;
    return r;
  endfunction

  always_comb begin
    phase_d     = phase_q;
    hdr_len_d   = hdr_len_q;
    hdr_cnt_d   = hdr_cnt_q;
    field_cnt_d = field_cnt_q;
    off_zero_d  = off_zero_q;
    blk_rem_d   = blk_rem_q;
    sum_d       = sum_q;
    res_o       = '0;
    unique case (phase_q)
      PhIdle: begin
        if (byte_i != ChrSoh) begin
          res_o = mk_res('0, KindError, ErrNoSoh);
        end else begin
          hdr_len_d   = '0;
          hdr_cnt_d   = '0;
          field_cnt_d = '0;
          off_zero_d  = 1'b0;
          blk_rem_d   = '0;
          sum_d       = '0;
          phase_d     = PhHlen;
        end
      end
      PhHlen: begin
        hdr_len_d   = byte_i;
        hdr_cnt_d   = '0;
        field_cnt_d = '0;
        phase_d     = PhTitle;
      end
      PhTitle: begin
        hdr_cnt_d = hdr_cnt_inc;
        if (byte_i == ChrNul) begin
          field_cnt_d = '0;
          off_zero_d  = 1'b0;
          phase_d     = PhOffset;
        end else if (field_cnt_q >= FcW'(TitleMax)) begin
          res_o   = mk_res('0, KindError, ErrNoNul);
          phase_d = PhIdle;
        end else begin
          field_cnt_d = field_cnt_q + FcW'(1);
        end
      end
      PhOffset: begin
        hdr_cnt_d = hdr_cnt_inc;
        if (byte_i == ChrNul) begin
          if (hdr_cnt_inc != hdr_len_q) begin
            res_o   = mk_res('0, KindError, ErrHdrLen);
            phase_d = PhIdle;
          end else if (!off_zero_q) begin
            res_o   = mk_res('0, KindError, ErrOffset);
            phase_d = PhIdle;
          end else begin
            sum_d   = '0;
            phase_d = PhBody;
          end
        end else if (field_cnt_q >= FcW'(OffsetMax)) begin
          res_o   = mk_res('0, KindError, ErrNoNul);
          phase_d = PhIdle;
        end else begin
          off_zero_d  = (field_cnt_q == '0) && (byte_i == AsciiZero);
          field_cnt_d = field_cnt_q + FcW'(1);
        end
      end
      PhBody: begin
        if (byte_i == ChrStx) begin
          phase_d = PhCount;
        end else if (byte_i == ChrEot) begin
          phase_d = PhCheck;
        end else begin
          res_o   = mk_res('0, KindError, ErrBodyByte);
          phase_d = PhIdle;
        end
      end
      PhCount: begin
        blk_rem_d = (byte_i == '0) ? BlkW'(256) : BlkW'(byte_i);
        phase_d   = PhData;
      end
      PhData: begin
        sum_d     = sum_add;
        blk_rem_d = blk_rem_dec;
        if (blk_rem_dec == '0) begin
          phase_d = PhBody;
        end
        res_o = mk_res(byte_i, KindData, ErrNone);
      end
      PhCheck: begin
        phase_d = PhIdle;
        if (sum_add != '0) begin
          res_o = mk_res('0, KindError, ErrChecksum);
        end else begin
          res_o = mk_res('0, KindGood, ErrNone);
        end
      end
      default: begin
        phase_d = PhIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      hdr_len_q   <= '0;
      hdr_cnt_q   <= '0;
      field_cnt_q <= '0;
      off_zero_q  <= 1'b0;
      blk_rem_q   <= '0;
      sum_q       <= '0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      hdr_len_q   <= hdr_len_d;
      hdr_cnt_q   <= hdr_cnt_d;
      field_cnt_q <= field_cnt_d;
      off_zero_q  <= off_zero_d;
      blk_rem_q   <= blk_rem_d;
      sum_q       <= sum_d;
    end
  end

endmodule

### src/cbd_out_reg.sv
// Result register of the compressed block deframer: holds one result until
// the downstream side takes it. Depends on cbd_pkg.
module cbd_out_reg
  import cbd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  cbd_res_t         res_i,
  input  logic             stall_i,
  output logic             valid_o,
  output logic [ByteW-1:0] data_o,
  output logic [KindW-1:0] kind_o,
  output logic [ErrW-1:0]  err_o
);

  logic             valid_q;
  logic [ByteW-1:0] data_q;
  logic [KindW-1:0] kind_q;
  logic [ErrW-1:0]  err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= res_i.valid;
    end else if (valid_q && !stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_i.valid) begin
      data_q <= res_i.data;
      kind_q <= res_i.kind;
      err_q  <= res_i.err;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign kind_o  = kind_q;
  assign err_o   = err_q;

endmodule
